@@ rtl/core/ahf_pkg.sv @@
// Shared types, constants and helpers for the ASCII hex feedback frame parser.
// No dependencies; ahf_seq and the top unit import this package, ahf_ram does not.
package ahf_pkg;

    // Byte store: one entry per held byte, addressed as a ring.
    localparam int unsigned STORE_DEPTH = 27;
    localparam int unsigned IDX_W       = 5;

    localparam logic [IDX_W-1:0] FRAME_OVERHEAD = IDX_W'(12);
    localparam logic [IDX_W-1:0] HEADER_SPAN    = IDX_W'(6);
    localparam logic [3:0]       ANGLE_CHARS    = 4'd12;

    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_T_UP = 8'h54;
    localparam logic [7:0] CHAR_T_LO = 8'h74;
    localparam logic [7:0] CHAR_P_UP = 8'h50;
    localparam logic [7:0] CHAR_P_LO = 8'h70;
    localparam logic [23:0] ID_GAC   = 24'h474143;

    // A nibble is 0..15; this code marks a character that is not a hex digit.
    localparam logic [4:0] NO_NIBBLE = 5'd16;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_CSUM    = 2'd1;
    localparam logic [1:0] STATUS_OTHER   = 2'd2;
    localparam logic [1:0] STATUS_BAD_ANG = 2'd3;

    typedef struct packed {
        logic [1:0]         status;
        logic [23:0]        id;
        logic [3:0]         len;
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
    } result_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [7:0]       wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } ram_req_t;

    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [4:0] n;
        if (c >= 8'h30 && c <= 8'h39) begin
            n = 5'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            n = 5'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            n = 5'(c - 8'h57);
        end else begin
            n = NO_NIBBLE;
        end
        return n;
    endfunction

    // Ring address: both operands are at most the depth, so one subtraction suffices.
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (IDX_W+1)'(STORE_DEPTH)) begin
            s = s - (IDX_W+1)'(STORE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

@@ rtl/core/ascii_hex_feedback_frame_parser_unit.sv @@
// The byte that completes a frame of 12 to 27 bytes starts a read-back of the
// frame from the byte RAM, one byte per cycle unless a finished frame is held for the
// output register, and m_tvalid rises from a register that the scanner's result sets.
// The parser takes one byte at a time: s_tready stays low while the held bytes are
// rescanned after each input transfer, and longer while a finished frame waits for
// m_tready. Reset (aresetn low, synchronous) empties the store and output.
module ascii_hex_feedback_frame_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] frame_status, [25:2] frame_id, [29:26] payload_length,
    // [45:30] yaw_centideg, [61:46] pitch_centideg, [77:62] roll_centideg
    output logic [79:0] m_tdata
);
    import ahf_pkg::*;

    ram_req_t   ram_req;
    logic [7:0] ram_rd_data;
    logic       res_valid;
    result_t    res;
    logic       out_full;
    logic       m_valid_reg;
    result_t    out_reg;

    ahf_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd_data)
    );

    ahf_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_byte     (s_tdata),
        .in_ready    (s_tready),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data),
        .out_full    (out_full),
        .res_valid   (res_valid),
        .res         (res)
    );

    // The scanner holds its finished frame until this register can take it.
    assign out_full = m_valid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_reg.roll, out_reg.pitch, out_reg.yaw,
                       out_reg.len, out_reg.id, out_reg.status};

endmodule

@@ rtl/core/ahf_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
module ahf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 27
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/ahf_seq.sv @@
// Frame scanner: keeps the held bytes as a ring in the byte RAM and walks them
// from the oldest byte after every received byte. Depends on ahf_pkg.
module ahf_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [7:0]        in_byte,
    output logic              in_ready,
    output ahf_pkg::ram_req_t ram_req,
    input  logic [7:0]        ram_rd_data,
    input  logic              out_full,
    output logic              res_valid,
    output ahf_pkg::result_t  res
);
    import ahf_pkg::*;

    localparam logic STATE_IDLE = 1'b0;
    localparam logic STATE_SCAN = 1'b1;

    localparam logic [IDX_W-1:0] OFF_MARK       = IDX_W'(0);
    localparam logic [IDX_W-1:0] OFF_T          = IDX_W'(1);
    localparam logic [IDX_W-1:0] OFF_P          = IDX_W'(2);
    localparam logic [IDX_W-1:0] OFF_LEN        = IDX_W'(5);
    localparam logic [IDX_W-1:0] OFF_ID0        = IDX_W'(7);
    localparam logic [IDX_W-1:0] OFF_ID1        = IDX_W'(8);
    localparam logic [IDX_W-1:0] OFF_ID2        = IDX_W'(9);
    localparam logic [IDX_W-1:0] OFF_DATA_FIRST = IDX_W'(10);
    localparam logic [IDX_W-1:0] OFF_DATA_LAST  = IDX_W'(21);

    logic             state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] off_reg, off_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_off_reg, pend_off_next;
    logic [IDX_W-1:0] total_reg, total_next;
    logic [3:0]       len_reg, len_next;
    logic [7:0]       sum_reg, sum_next;
    logic [23:0]      id_reg, id_next;
    logic [47:0]      ang_reg, ang_next;
    logic             hexbad_reg, hexbad_next;
    logic [4:0]       hi_reg, hi_next;
    logic             emitted_reg, emitted_next;

    logic [7:0]       d;
    logic [4:0]       nib;
    logic             at_end, stall, act;
    logic             drop_one, finish, complete;
    logic [IDX_W-1:0] drop_cnt;
    logic             cs_ok, ang_ok;

    assign d   = ram_rd_data;
    assign nib = nibble_of(d);

    // The last byte of a complete frame is in hand; a frame is at least 12 bytes.
    assign at_end = pend_reg && (pend_off_reg > OFF_LEN) &&
                    (pend_off_reg == total_reg - IDX_W'(1));
    assign stall  = at_end && !emitted_reg && out_full;
    assign act    = pend_reg && !stall && (state_reg == STATE_SCAN);

    assign cs_ok  = (hi_reg != NO_NIBBLE) && (nib != NO_NIBBLE) &&
                    (sum_reg == {hi_reg[3:0], nib[3:0]});
    assign ang_ok = (len_reg >= ANGLE_CHARS) && !hexbad_reg;

    always_comb begin
        res.id    = id_reg;
        res.len   = len_reg;
        res.yaw   = '0;
        res.pitch = '0;
        res.roll  = '0;
        priority if (!cs_ok) begin
            res.status = STATUS_CSUM;
        end else if (id_reg != ID_GAC) begin
            res.status = STATUS_OTHER;
        end else if (!ang_ok) begin
            res.status = STATUS_BAD_ANG;
        end else begin
            res.status = STATUS_OK;
            res.yaw    = ang_reg[47:32];
            res.pitch  = ang_reg[31:16];
            res.roll   = ang_reg[15:0];
        end
    end

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        off_next      = off_reg;
        pend_next     = pend_reg;
        pend_off_next = pend_off_reg;
        total_next    = total_reg;
        len_next      = len_reg;
        sum_next      = sum_reg;
        id_next       = id_reg;
        ang_next      = ang_reg;
        hexbad_next   = hexbad_reg;
        hi_next       = hi_reg;
        emitted_next  = emitted_reg;
        drop_one      = 1'b0;
        finish        = 1'b0;
        complete      = 1'b0;
        res_valid     = 1'b0;
        in_ready      = (state_reg == STATE_IDLE);

        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = wrap_add(head_reg, count_reg);
        ram_req.wr_data = in_byte;
        ram_req.rd_en   = 1'b0;
        ram_req.rd_addr = wrap_add(head_reg, off_reg);

        unique case (state_reg)
            STATE_IDLE: begin
                if (in_valid) begin
                    ram_req.wr_en = 1'b1;
                    count_next    = count_reg + IDX_W'(1);
                    emitted_next  = 1'b0;
                    pend_next     = 1'b0;
                    off_next      = OFF_MARK;
                    state_next    = STATE_SCAN;
                end
            end
            STATE_SCAN: begin
                if (act) begin
                    if (pend_off_reg == OFF_MARK) begin
                        sum_next    = d;
                        hexbad_next = 1'b0;
                        if (d != CHAR_HASH) begin
                            drop_one = 1'b1;
                        end else if (count_reg < HEADER_SPAN) begin
                            finish = 1'b1;
                        end
                    end else if (pend_off_reg <= OFF_LEN ||
                                 pend_off_reg < total_reg - IDX_W'(2)) begin
                        sum_next = sum_reg + d;
                    end
                    if (pend_off_reg == OFF_T && d != CHAR_T_UP && d != CHAR_T_LO) begin
                        drop_one = 1'b1;
                    end
                    if (pend_off_reg == OFF_P && d != CHAR_P_UP && d != CHAR_P_LO) begin
                        drop_one = 1'b1;
                    end
                    if (pend_off_reg == OFF_LEN) begin
                        if (nib == NO_NIBBLE) begin
                            drop_one = 1'b1;
                        end else begin
                            len_next   = nib[3:0];
                            total_next = FRAME_OVERHEAD + IDX_W'(nib);
                            if (count_reg < FRAME_OVERHEAD + IDX_W'(nib)) begin
                                finish = 1'b1;
                            end
                        end
                    end
                    if (pend_off_reg == OFF_ID0) id_next[23:16] = d;
                    if (pend_off_reg == OFF_ID1) id_next[15:8]  = d;
                    if (pend_off_reg == OFF_ID2) id_next[7:0]   = d;
                    if (pend_off_reg >= OFF_DATA_FIRST && pend_off_reg <= OFF_DATA_LAST) begin
                        ang_next = {ang_reg[43:0], nib[3:0]};
                        if (nib == NO_NIBBLE) begin
                            hexbad_next = 1'b1;
                        end
                    end
                    if (pend_off_reg > OFF_LEN && pend_off_reg == total_reg - IDX_W'(2)) begin
                        hi_next = nib;
                    end
                    if (at_end) begin
                        complete = 1'b1;
                        // Only the first frame finished for a received byte is reported.
                        if (!emitted_reg) begin
                            res_valid    = 1'b1;
                            emitted_next = 1'b1;
                        end
                    end
                end

                drop_cnt = drop_one ? IDX_W'(1) : total_reg;
                if (drop_one || complete) begin
                    head_next  = wrap_add(head_reg, drop_cnt);
                    count_next = count_reg - drop_cnt;
                    off_next   = OFF_MARK;
                    pend_next  = 1'b0;
                    if (count_reg == drop_cnt) begin
                        state_next = STATE_IDLE;
                    end
                end else if (finish) begin
                    pend_next  = 1'b0;
                    state_next = STATE_IDLE;
                end else if (!stall) begin
                    ram_req.rd_en = 1'b1;
                    pend_next     = 1'b1;
                    pend_off_next = off_reg;
                    off_next      = off_reg + IDX_W'(1);
                end
            end
            default: begin
                state_next = STATE_IDLE;
            end
        endcase
        if (state_reg != STATE_SCAN) begin
            drop_cnt = total_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= STATE_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            off_reg     <= '0;
            pend_reg    <= 1'b0;
            emitted_reg <= 1'b0;
            total_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            off_reg     <= off_next;
            pend_reg    <= pend_next;
            emitted_reg <= emitted_next;
            total_reg   <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_off_reg <= pend_off_next;
        len_reg      <= len_next;
        sum_reg      <= sum_next;
        id_reg       <= id_next;
        ang_reg      <= ang_next;
        hexbad_reg   <= hexbad_next;
        hi_reg       <= hi_next;
    end

    // A partial frame never fills the whole store while waiting for bytes.
    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == STATE_IDLE |-> count_reg < IDX_W'(STORE_DEPTH))
        else $error("held byte count reached the store depth at rest");

    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg < IDX_W'(STORE_DEPTH))
        else $error("ring head outside the store");

    a_frame_len: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> pend_off_reg >= FRAME_OVERHEAD - IDX_W'(1))
        else $error("result reported for a frame shorter than the overhead");

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> !res_valid || state_reg == STATE_IDLE)
        else $error("two results reported for one received byte");

endmodule
